// ===== rtl/wave_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// wave_header_parser_macros.svh
// Assertion macros used by the checker file of the WAVE header parser.
// ----------------------------------------------------------------------------
`ifndef WAVE_HEADER_PARSER_MACROS_SVH
`define WAVE_HEADER_PARSER_MACROS_SVH

// Implication checked on every rising edge, masked while reset is low.
`define WHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define WHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/whp_pkg.sv =====
// ----------------------------------------------------------------------------
// whp_pkg
// Types and constants of the WAVE header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whp_pkg;

  // chunk tags as seen in a 32-bit little-endian window
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // byte offsets where the header checks fire (offset of the last byte in window)
  localparam logic [31:0] PosRiffEnd = 32'd3;
  localparam logic [31:0] PosWaveEnd = 32'd11;
  localparam logic [31:0] PosFmtEnd  = 32'd15;
  localparam logic [31:0] PosFmtSize = 32'd19;
  localparam logic [31:0] PosFmt0End = 32'd27;
  localparam logic [31:0] PosFmt1End = 32'd35;
  localparam logic [31:0] PosWalkMin = 32'd27;
  // a buffer whose last byte sits at or below this offset is too small
  localparam logic [31:0] PosTooSmall = 32'd43;
  localparam logic [31:0] PosMax      = 32'hFFFF_FFFF;

  localparam int unsigned OutDataW = 200;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_NOT_RIFF  = 3'd2,
    ST_NOT_WAVE  = 3'd3,
    ST_NO_FMT    = 3'd4,
    ST_NO_DATA   = 3'd5,
    ST_SIZE_ZERO = 3'd6
  } status_e;

  // one input beat held in the input register
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [15:0] sample_width;
    logic [15:0] frame_size;
    logic [31:0] bytes_per_sec;
    logic [31:0] samples_per_sec;
    logic [15:0] channel_count;
    logic [15:0] format_code;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/whp_in_stage.sv =====
// ----------------------------------------------------------------------------
// whp_in_stage
// Input register: holds one byte beat until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,
  input  wire logic          s_axis_tlast,
  input  wire logic          take_i,
  output whp_pkg::beat_t     beat_o
);
  import whp_pkg::*;

  logic       valid_q, valid_d;
  logic       last_q;
  logic [7:0] data_q;
  logic       load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign beat_o = '{valid: valid_q, last: last_q, data: data_q};

endmodule

`default_nettype wire

// ===== rtl/whp_core.sv =====
// ----------------------------------------------------------------------------
// whp_core
// Parser state: byte counter, 8-byte window, chunk walk and fmt capture.
// Builds the result for a last beat from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  whp_pkg::beat_t      beat_i,
  input  wire logic           out_free_i,
  output logic                take_o,
  output logic                load_o,
  output whp_pkg::result_t    result_o
);
  import whp_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [63:0] win_q, win_d;
  logic [32:0] nhp_q, nhp_d;
  logic [63:0] fmt0_q, fmt0_d;
  logic [63:0] fmt1_q, fmt1_d;
  logic        found_q, found_d;
  logic [31:0] off_q, off_d;
  logic [31:0] size_q, size_d;
  status_e     err_q, err_d;

  logic [31:0] lo, hi;
  logic        parse, hit;
  logic [33:0] hdr_end;
  status_e     status;

  // a last beat needs the output slot; other beats always go through
  assign take_o = beat_i.valid && (!beat_i.last || out_free_i);
  assign load_o = take_o && beat_i.last;

  assign win_d   = {beat_i.data, win_q[63:8]};
  assign lo      = win_d[31:0];
  assign hi      = win_d[63:32];
  assign parse   = pos_q != PosMax;
  assign hdr_end = {1'b0, nhp_q} + 34'd7;
  assign hit     = parse && !found_q && (pos_q >= PosWalkMin) && ({2'b00, pos_q} == hdr_end);

  always_comb begin
    pos_d   = pos_q;
    nhp_d   = nhp_q;
    fmt0_d  = fmt0_q;
    fmt1_d  = fmt1_q;
    found_d = found_q;
    off_d   = off_q;
    size_d  = size_q;
    err_d   = err_q;
    if (parse) begin
      pos_d = pos_q + 32'd1;
      if (err_q == ST_OK) begin
        if (pos_q == PosRiffEnd && hi != TagRiff) begin
          err_d = ST_NOT_RIFF;
        end else if (pos_q == PosWaveEnd && hi != TagWave) begin
          err_d = ST_NOT_WAVE;
        end else if (pos_q == PosFmtEnd && hi != TagFmt) begin
          err_d = ST_NO_FMT;
        end
      end
      if (pos_q == PosFmtSize) begin
        nhp_d = {1'b0, hi} + 33'd20;
      end
      if (pos_q == PosFmt0End) begin
        fmt0_d = win_d;
      end
      if (pos_q == PosFmt1End) begin
        fmt1_d = win_d;
      end
      if (hit) begin
        if (lo == TagData) begin
          found_d = 1'b1;
          off_d   = pos_q + 32'd1;
          size_d  = hi;
        end else begin
          // header sits below 2^32, so the skip stays within 33 bits
          nhp_d = nhp_q + {1'b0, hi} + 33'd8;
        end
      end
    end
  end

  always_comb begin
    if (pos_q <= PosTooSmall) begin
      status = ST_TOO_SMALL;
    end else if (err_d != ST_OK) begin
      status = err_d;
    end else if (!found_d) begin
      status = ST_NO_DATA;
    end else if (size_d == 32'd0) begin
      status = ST_SIZE_ZERO;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result_o        = '0;
    result_o.status = status;
    if (status == ST_OK || status == ST_NO_DATA || status == ST_SIZE_ZERO) begin
      result_o.format_code     = fmt0_d[15:0];
      result_o.channel_count   = fmt0_d[31:16];
      result_o.samples_per_sec = fmt0_d[63:32];
      result_o.bytes_per_sec   = fmt1_d[31:0];
      result_o.frame_size      = fmt1_d[47:32];
      result_o.sample_width    = fmt1_d[63:48];
    end
    if (status == ST_OK || status == ST_SIZE_ZERO) begin
      result_o.data_offset = off_d;
      result_o.data_size   = size_d;
    end
  end

  // after the last beat every register starts over for the next buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      win_q   <= '0;
      nhp_q   <= '0;
      fmt0_q  <= '0;
      fmt1_q  <= '0;
      found_q <= 1'b0;
      off_q   <= '0;
      size_q  <= '0;
      err_q   <= ST_OK;
    end else if (take_o) begin
      if (beat_i.last) begin
        pos_q   <= '0;
        win_q   <= '0;
        nhp_q   <= '0;
        fmt0_q  <= '0;
        fmt1_q  <= '0;
        found_q <= 1'b0;
        off_q   <= '0;
        size_q  <= '0;
        err_q   <= ST_OK;
      end else begin
        pos_q   <= pos_d;
        win_q   <= win_d;
        nhp_q   <= nhp_d;
        fmt0_q  <= fmt0_d;
        fmt1_q  <= fmt1_d;
        found_q <= found_d;
        off_q   <= off_d;
        size_q  <= size_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/whp_out_stage.sv =====
// ----------------------------------------------------------------------------
// whp_out_stage
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  whp_pkg::result_t   result_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output whp_pkg::result_t   result_o
);
  import whp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign result_o      = res_q;

endmodule

`default_nettype wire

// ===== rtl/wave_header_parser.sv =====
// ----------------------------------------------------------------------------
// wave_header_parser
// RIFF/WAVE header parser taking one file byte per beat.
// ----------------------------------------------------------------------------
// Feed the file bytes in order on the slave stream, tlast on the final byte.
// Each byte is registered in the input stage, then the parser core updates
// its window, tag checks, fmt capture and chunk walk in the next cycle, so
// the block accepts a byte on every cycle while the output side keeps up.
// For each tlast beat the core loads one result beat into the output register;
// while a result waits on m_axis_tready, ordinary bytes still go through and
// only the next tlast byte stalls. Status codes: 0 ok, 1 too small (44 bytes
// or fewer), 2 not RIFF, 3 not WAVE, 4 no fmt, 5 no data, 6 data size zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_header_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [2:0] status, [18:3] format_code, [34:19] channel_count,
  // [66:35] samples_per_sec, [98:67] bytes_per_sec, [114:99] frame_size,
  // [130:115] sample_width, [162:131] data_offset, [194:163] data_size,
  // [199:195] zero
  output logic [whp_pkg::OutDataW-1:0] m_axis_tdata
);
  import whp_pkg::*;

  beat_t   beat;
  result_t core_res, out_res;
  logic    take, load, out_free;

  whp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .beat_o        (beat)
  );

  whp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .out_free_i (out_free),
    .take_o     (take),
    .load_o     (load),
    .result_o   (core_res)
  );

  whp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .result_i      (core_res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result_o      (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res};

endmodule

`default_nettype wire

// ===== rtl/whp_checker.sv =====
// ----------------------------------------------------------------------------
// whp_checker
// Port-level checks of the WAVE header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wave_header_parser_macros.svh"

module whp_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [199:0] m_axis_tdata
);
  import whp_pkg::*;

  logic [2:0] st;
  logic       err_st;
  logic       fmt_st;
  logic       pad_ok;

  assign st     = m_axis_tdata[2:0];
  assign err_st = (st == ST_TOO_SMALL) || (st == ST_NOT_RIFF) || (st == ST_NOT_WAVE) ||
                  (st == ST_NO_FMT);
  assign fmt_st = (st == ST_NO_DATA) || (st == ST_SIZE_ZERO);
  assign pad_ok = (m_axis_tdata[199:195] == 5'd0);

  `WHP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "beat dropped")
  `WHP_ASSERT_IMP(a_status, m_axis_tvalid, st <= ST_SIZE_ZERO && pad_ok, "bad status or pad")
  `WHP_ASSERT_IMP(a_err_zero, m_axis_tvalid && err_st, m_axis_tdata[194:3] == '0, "fields set")
  `WHP_ASSERT_IMP(a_nodata, m_axis_tvalid && fmt_st, m_axis_tdata[194:163] == '0, "size set")

endmodule

bind wave_header_parser whp_checker u_whp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
